FILE: rtl/core/slps_pkg.sv
// ============================================================================
// Status LED pattern sequencer - shared package
// Transaction types, state codes, colour constants and the constant-divisor
// reciprocals used by the time remainder pipeline.
// ============================================================================
package slps_pkg;

    // Input transaction: one display tick.
    typedef struct packed {
        logic [31:0] now_ms;
        logic [2:0]  printer_state;
        logic        paper_hint;
        logic        wifi_expected;
        logic        wifi_linked;
        logic [1:0]  mode;
    } tick_t;

    // Output transaction: one LED colour.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       transient_shown;
    } result_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam rgb_t RGB_OFF    = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    localparam rgb_t RGB_WHITE  = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    localparam rgb_t RGB_GREEN  = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
    localparam rgb_t RGB_BLUE   = '{red: 8'd0,   green: 8'd70,  blue: 8'd255};
    localparam rgb_t RGB_CYAN   = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
    localparam rgb_t RGB_ORANGE = '{red: 8'd255, green: 8'd70,  blue: 8'd0};
    localparam rgb_t RGB_RED    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};

    // Printer state codes.
    localparam logic [2:0] PS_READY        = 3'd0;
    localparam logic [2:0] PS_PRINTING     = 3'd1;
    localparam logic [2:0] PS_PAPER_LOW    = 3'd2;
    localparam logic [2:0] PS_PAPER_OUT    = 3'd3;
    localparam logic [2:0] PS_PRINT_FAILED = 3'd4;
    localparam logic [2:0] PS_ERROR        = 3'd5;

    // Trigger codes.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_BUTTON = 2'd1;
    localparam logic [1:0] MODE_REMOTE = 2'd2;

    // Transient pattern kinds.
    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_BUTTON  = 3'd1,
        KIND_REMOTE  = 3'd2,
        KIND_WIFI    = 3'd3,
        KIND_SUCCESS = 3'd4,
        KIND_FAILED  = 3'd5
    } kind_t;

    // Longest transient is 900 ms, so a live elapsed time fits 10 bits.
    localparam int ELAPSED_W = 10;

    typedef struct packed {
        logic                 shown;
        kind_t                kind;
        logic [ELAPSED_W-1:0] elapsed;
    } trans_t;

    // Per-transaction side information carried alongside the remainder pipeline.
    typedef struct packed {
        logic [2:0] printer_state;
        logic       paper_hint;
        logic       wifi_expected;
        logic       wifi_linked;
        trans_t     trans;
    } side_t;

    // Pipeline load enables for the remainder unit.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // Base pattern periods in ms. All divide the common period below.
    localparam int DIV_BLINK = 160;   // printing blink
    localparam int DIV_OUT   = 1600;  // paper out
    localparam int DIV_LOW   = 2200;  // paper low and ready heartbeat
    localparam int DIV_PROV  = 500;   // unprovisioned
    localparam int DIV_LINK  = 1000;  // disconnected
    localparam int DIV_LCM   = 88000; // common multiple of all periods

    // First reduction: 32-bit time modulo the common period.
    localparam int LCM_Q_W   = 16;
    localparam int LCM_RAW_W = 18;
    localparam int LCM_REM_W = 17;
    localparam logic [LCM_Q_W-1:0] RECIP_LCM =
        LCM_Q_W'((64'd1 << 32) / 64'(DIV_LCM));

    // Second reduction: common remainder modulo each period.
    localparam int FRAC_W = LCM_REM_W;
    localparam int Q_W    = 10;
    localparam int REM_W  = 12;
    localparam logic [Q_W-1:0] RECIP_BLINK = Q_W'((64'd1 << FRAC_W) / 64'(DIV_BLINK));
    localparam logic [Q_W-1:0] RECIP_OUT   = Q_W'((64'd1 << FRAC_W) / 64'(DIV_OUT));
    localparam logic [Q_W-1:0] RECIP_LOW   = Q_W'((64'd1 << FRAC_W) / 64'(DIV_LOW));
    localparam logic [Q_W-1:0] RECIP_PROV  = Q_W'((64'd1 << FRAC_W) / 64'(DIV_PROV));
    localparam logic [Q_W-1:0] RECIP_LINK  = Q_W'((64'd1 << FRAC_W) / 64'(DIV_LINK));

    typedef struct packed {
        logic [REM_W-1:0] blink;
        logic [REM_W-1:0] no_paper;
        logic [REM_W-1:0] low_paper;
        logic [REM_W-1:0] prov;
        logic [REM_W-1:0] link;
    } rem_t;

endpackage

FILE: rtl/core/slps_transient.sv
// ============================================================================
// Status LED pattern sequencer - transient tracker
// Holds the single transient pattern and the previous-tick flags; decides
// per transaction which transient is live and how far into it the tick is.
// ============================================================================
module slps_transient (
    input  logic           clk,
    input  logic           rst_n,
    input  slps_pkg::tick_t tick,
    input  logic           advance,
    output slps_pkg::trans_t trans
);
    import slps_pkg::*;

    kind_t       kind_reg;
    kind_t       kind_mid;
    kind_t       kind_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic        prev_printing_reg;
    logic        prev_expected_reg;
    logic        prev_connected_reg;
    logic        printing;
    logic [31:0] elapsed;
    logic        live;
    logic        expired;

    function automatic logic [ELAPSED_W-1:0] duration(input kind_t k);
        case (k)
            KIND_BUTTON:  return ELAPSED_W'(120);
            KIND_REMOTE:  return ELAPSED_W'(240);
            KIND_WIFI:    return ELAPSED_W'(420);
            KIND_SUCCESS: return ELAPSED_W'(640);
            KIND_FAILED:  return ELAPSED_W'(900);
            default:      return '0;
        endcase
    endfunction

    assign printing = (tick.printer_state == PS_PRINTING);

    always_comb
    begin
        kind_mid   = kind_reg;
        start_next = start_reg;
        // Later events in the same tick replace earlier ones.
        case (tick.mode)
            MODE_BUTTON:
            begin
                kind_mid   = KIND_BUTTON;
                start_next = tick.now_ms;
            end
            MODE_REMOTE:
            begin
                kind_mid   = KIND_REMOTE;
                start_next = tick.now_ms;
            end
            default:
            begin
                kind_mid = kind_reg;
            end
        endcase
        if (tick.wifi_expected && tick.wifi_linked &&
            (!prev_expected_reg || !prev_connected_reg))
        begin
            kind_mid   = KIND_WIFI;
            start_next = tick.now_ms;
        end
        if (prev_printing_reg && !printing)
        begin
            if (tick.printer_state == PS_PRINT_FAILED || tick.printer_state == PS_ERROR ||
                tick.printer_state == PS_PAPER_OUT)
                kind_mid = KIND_FAILED;
            else
                kind_mid = KIND_SUCCESS;
            start_next = tick.now_ms;
        end
        elapsed   = tick.now_ms - start_next;
        live      = !printing && (kind_mid != KIND_NONE);
        expired   = (elapsed >= 32'(duration(kind_mid)));
        kind_next = (live && expired) ? KIND_NONE : kind_mid;

        trans.shown   = live && !expired;
        trans.kind    = kind_mid;
        trans.elapsed = elapsed[ELAPSED_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg           <= KIND_NONE;
            start_reg          <= '0;
            prev_printing_reg  <= 1'b0;
            prev_expected_reg  <= 1'b0;
            prev_connected_reg <= 1'b0;
        end
        else if (advance)
        begin
            kind_reg           <= kind_next;
            start_reg          <= start_next;
            prev_printing_reg  <= printing;
            prev_expected_reg  <= tick.wifi_expected;
            prev_connected_reg <= tick.wifi_linked;
        end
    end

endmodule

FILE: rtl/core/slps_time_div.sv
// ============================================================================
// Status LED pattern sequencer - time remainder pipeline
// Reduces the millisecond time modulo each base pattern period by reciprocal
// multiplication: first modulo the common period, then modulo each period.
// ============================================================================
module slps_time_div (
    input  logic                clk,
    input  logic [31:0]         now_ms,
    input  slps_pkg::stage_en_t en,
    output slps_pkg::rem_t      rem
);
    import slps_pkg::*;

    // Stage 2: estimated quotient by the common period.
    logic [31:0]          now_reg;
    logic [LCM_Q_W-1:0]   q_lcm_reg;
    logic [47:0]          lcm_prod;
    // Stage 3: remainder modulo the common period.
    logic [LCM_RAW_W-1:0] lcm_raw;
    logic [LCM_REM_W-1:0] lcm_rem_next;
    logic [LCM_REM_W-1:0] lcm_rem_reg;
    // Stage 4: estimated quotient per period.
    logic [LCM_REM_W-1:0] lcm_rem4_reg;
    logic [Q_W-1:0]       q_blink_reg;
    logic [Q_W-1:0]       q_out_reg;
    logic [Q_W-1:0]       q_low_reg;
    logic [Q_W-1:0]       q_prov_reg;
    logic [Q_W-1:0]       q_link_reg;
    logic [FRAC_W+Q_W-1:0] p_blink;
    logic [FRAC_W+Q_W-1:0] p_out;
    logic [FRAC_W+Q_W-1:0] p_low;
    logic [FRAC_W+Q_W-1:0] p_prov;
    logic [FRAC_W+Q_W-1:0] p_link;

    // Estimate is low by at most one, so the raw remainder is below twice
    // the divisor: one compare and subtract finishes it.
    function automatic logic [REM_W-1:0] fix_rem(
        input logic [LCM_REM_W-1:0] r,
        input logic [Q_W-1:0]       q,
        input logic [LCM_REM_W-1:0] d
    );
        logic [LCM_REM_W-1:0] raw;
        raw = r - LCM_REM_W'(q * d);
        if (raw >= d)
            raw = raw - d;
        return raw[REM_W-1:0];
    endfunction

    assign lcm_prod = 48'(now_ms) * 48'(RECIP_LCM);

    assign lcm_raw      = now_reg[LCM_RAW_W-1:0] - LCM_RAW_W'(q_lcm_reg * LCM_RAW_W'(DIV_LCM));
    assign lcm_rem_next = (lcm_raw >= LCM_RAW_W'(DIV_LCM)) ?
                          LCM_REM_W'(lcm_raw - LCM_RAW_W'(DIV_LCM)) :
                          LCM_REM_W'(lcm_raw);

    assign p_blink = (FRAC_W+Q_W)'(lcm_rem_reg) * (FRAC_W+Q_W)'(RECIP_BLINK);
    assign p_out   = (FRAC_W+Q_W)'(lcm_rem_reg) * (FRAC_W+Q_W)'(RECIP_OUT);
    assign p_low   = (FRAC_W+Q_W)'(lcm_rem_reg) * (FRAC_W+Q_W)'(RECIP_LOW);
    assign p_prov  = (FRAC_W+Q_W)'(lcm_rem_reg) * (FRAC_W+Q_W)'(RECIP_PROV);
    assign p_link  = (FRAC_W+Q_W)'(lcm_rem_reg) * (FRAC_W+Q_W)'(RECIP_LINK);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            now_reg   <= now_ms;
            q_lcm_reg <= lcm_prod[47:32];
        end
        if (en.s3)
            lcm_rem_reg <= lcm_rem_next;
        if (en.s4)
        begin
            lcm_rem4_reg <= lcm_rem_reg;
            q_blink_reg  <= p_blink[FRAC_W+Q_W-1:FRAC_W];
            q_out_reg    <= p_out[FRAC_W+Q_W-1:FRAC_W];
            q_low_reg    <= p_low[FRAC_W+Q_W-1:FRAC_W];
            q_prov_reg   <= p_prov[FRAC_W+Q_W-1:FRAC_W];
            q_link_reg   <= p_link[FRAC_W+Q_W-1:FRAC_W];
        end
    end

    assign rem.blink     = fix_rem(lcm_rem4_reg, q_blink_reg, LCM_REM_W'(DIV_BLINK));
    assign rem.no_paper  = fix_rem(lcm_rem4_reg, q_out_reg,   LCM_REM_W'(DIV_OUT));
    assign rem.low_paper = fix_rem(lcm_rem4_reg, q_low_reg,   LCM_REM_W'(DIV_LOW));
    assign rem.prov      = fix_rem(lcm_rem4_reg, q_prov_reg,  LCM_REM_W'(DIV_PROV));
    assign rem.link      = fix_rem(lcm_rem4_reg, q_link_reg,  LCM_REM_W'(DIV_LINK));

endmodule

FILE: rtl/core/slps_colour.sv
// ============================================================================
// Status LED pattern sequencer - colour select
// Picks the base pattern colour by priority and overlays a live transient.
// ============================================================================
module slps_colour (
    input  slps_pkg::rem_t    rem,
    input  slps_pkg::side_t   side,
    output slps_pkg::result_t result
);
    import slps_pkg::*;

    rgb_t base;
    rgb_t trans_rgb;
    rgb_t final_rgb;

    function automatic logic kind_lit(input kind_t k, input logic [ELAPSED_W-1:0] e);
        case (k)
            KIND_BUTTON:  return (e < 10'd120);
            KIND_REMOTE:  return (e < 10'd80) || (e >= 10'd140 && e < 10'd220);
            KIND_WIFI:    return (e < 10'd140) || (e >= 10'd220 && e < 10'd360);
            // Even 80 ms slots up to the 640 ms duration.
            KIND_SUCCESS: return (e < 10'd80) || (e >= 10'd160 && e < 10'd240) ||
                                 (e >= 10'd320 && e < 10'd400) ||
                                 (e >= 10'd480 && e < 10'd560);
            // Even 75 ms slots up to the 900 ms duration.
            KIND_FAILED:  return (e < 10'd75) || (e >= 10'd150 && e < 10'd225) ||
                                 (e >= 10'd300 && e < 10'd375) ||
                                 (e >= 10'd450 && e < 10'd525) ||
                                 (e >= 10'd600 && e < 10'd675) ||
                                 (e >= 10'd750 && e < 10'd825);
            default:      return 1'b0;
        endcase
    endfunction

    function automatic rgb_t kind_rgb(input kind_t k);
        case (k)
            KIND_BUTTON:  return RGB_WHITE;
            KIND_REMOTE:  return RGB_CYAN;
            KIND_WIFI:    return RGB_GREEN;
            KIND_SUCCESS: return RGB_GREEN;
            KIND_FAILED:  return RGB_RED;
            default:      return RGB_OFF;
        endcase
    endfunction

    always_comb
    begin
        if (side.printer_state == PS_PRINTING)
            base = (rem.blink < REM_W'(80)) ? RGB_WHITE : RGB_OFF;
        else if (side.printer_state == PS_PAPER_OUT)
            base = ((rem.no_paper < REM_W'(120)) ||
                    (rem.no_paper >= REM_W'(240) && rem.no_paper < REM_W'(360)) ||
                    (rem.no_paper >= REM_W'(480) && rem.no_paper < REM_W'(600))) ?
                   RGB_RED : RGB_OFF;
        else if (side.printer_state == PS_PAPER_LOW || side.paper_hint)
            base = ((rem.low_paper < REM_W'(140)) ||
                    (rem.low_paper >= REM_W'(280) && rem.low_paper < REM_W'(420))) ?
                   RGB_ORANGE : RGB_OFF;
        else if (!side.wifi_expected)
            base = (rem.prov < REM_W'(250)) ? RGB_BLUE : RGB_OFF;
        else if (!side.wifi_linked)
            base = (rem.link < REM_W'(500)) ? RGB_BLUE : RGB_OFF;
        else
            base = (rem.low_paper < REM_W'(80)) ? RGB_GREEN : RGB_OFF;

        trans_rgb = kind_lit(side.trans.kind, side.trans.elapsed) ?
                    kind_rgb(side.trans.kind) : RGB_OFF;
        final_rgb = side.trans.shown ? trans_rgb : base;

        result.red             = final_rgb.red;
        result.green           = final_rgb.green;
        result.blue            = final_rgb.blue;
        result.transient_shown = side.trans.shown;
    end

endmodule

FILE: rtl/core/status_led_pattern_sequencer_top.sv
// ============================================================================
// Status LED pattern sequencer - top level
// Turns one display tick into one RGB colour through a short pipeline.
// ============================================================================
// Usage:
//   Input channel tick (tick_valid / tick_stall) carries one display tick:
//   time in ms, printer state, paper and Wi-Fi flags and a trigger code.
//   Output channel result (result_valid / result_stall) carries the colour
//   and whether it comes from a transient pattern. A transaction moves at a
//   rising edge with valid high and stall low.
//   Every tick gives exactly one result, in order.
//   The pipeline takes one transaction per cycle while tick_stall is low;
//   the stages are the input register, the common-period quotient, the
//   common remainder, the per-period quotients and the output register.
//   The transient state is updated as a tick leaves the input register, so
//   ticks see it in order. Reset clears all valid bits, the transient
//   (none) and the previous-tick flags. While result_stall is high the
//   output holds; stages behind it keep filling any empty slot, and
//   tick_stall rises only once every stage is full.
// ============================================================================
module status_led_pattern_sequencer_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    output logic              tick_stall,
    input  slps_pkg::tick_t   tick,
    output logic              result_valid,
    input  logic              result_stall,
    output slps_pkg::result_t result
);
    import slps_pkg::*;

    // Stage occupancy.
    logic    s1_valid_reg;
    logic    s2_valid_reg;
    logic    s3_valid_reg;
    logic    s4_valid_reg;
    logic    out_valid_reg;

    // A stage may load when it is empty or its contents move on this edge.
    logic    rdy1;
    logic    rdy2;
    logic    rdy3;
    logic    rdy4;
    logic    rdy5;

    tick_t     tick_reg;
    side_t     side2_reg;
    side_t     side3_reg;
    side_t     side4_reg;
    result_t   result_reg;
    trans_t    trans;
    rem_t      rem;
    result_t   colour_next;
    stage_en_t div_en;

    assign rdy5 = !out_valid_reg || !result_stall;
    assign rdy4 = !s4_valid_reg  || rdy5;
    assign rdy3 = !s3_valid_reg  || rdy4;
    assign rdy2 = !s2_valid_reg  || rdy3;
    assign rdy1 = !s1_valid_reg  || rdy2;

    assign tick_stall   = !rdy1;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // Load payload only where a real transaction moves.
    assign div_en.s2 = rdy2 && s1_valid_reg;
    assign div_en.s3 = rdy3 && s2_valid_reg;
    assign div_en.s4 = rdy4 && s3_valid_reg;

    // Transient tracker: advance once per tick as it leaves stage 1.
    slps_transient u_transient (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_reg),
        .advance (div_en.s2),
        .trans   (trans)
    );

    slps_time_div u_time_div (
        .clk    (clk),
        .now_ms (tick_reg.now_ms),
        .en     (div_en),
        .rem    (rem)
    );

    slps_colour u_colour (
        .rem    (rem),
        .side   (side4_reg),
        .result (colour_next)
    );

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= tick_valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
            if (rdy5)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // Payload: hold unless a transaction moves in.
    always_ff @(posedge clk)
    begin
        if (rdy1 && tick_valid)
            tick_reg <= tick;
        if (div_en.s2)
        begin
            side2_reg.printer_state <= tick_reg.printer_state;
            side2_reg.paper_hint    <= tick_reg.paper_hint;
            side2_reg.wifi_expected <= tick_reg.wifi_expected;
            side2_reg.wifi_linked   <= tick_reg.wifi_linked;
            side2_reg.trans         <= trans;
        end
        if (div_en.s3)
            side3_reg <= side2_reg;
        if (div_en.s4)
            side4_reg <= side3_reg;
        if (rdy5 && s4_valid_reg)
            result_reg <= colour_next;
    end

endmodule
